[hdl/tsfu_pkg.sv]
// Shared types and constants of the Taylor-series function unit.
package tsfu_pkg;

    // Function codes, as written to the function select register
    typedef enum logic [2:0] {
        F_SIN   = 3'd0,
        F_COS   = 3'd1,
        F_SINH  = 3'd2,
        F_COSH  = 3'd3,
        F_TANH  = 3'd4,
        F_EXP   = 3'd5,
        F_ATAN  = 3'd6,
        F_LN    = 3'd7
    } t_func;

    // Register indexes of the configuration port
    localparam logic [0:0] REG_FUNC  = 1'b0;
    localparam logic [0:0] REG_TERMS = 1'b1;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_TB_START,
        S_TB_STEP,
        S_CV_RDA,
        S_CV_RDB,
        S_CV_MUL,
        S_CV_WAIT,
        S_TB_DSTART,
        S_TB_DIV,
        S_EV_START,
        S_LN_HI,
        S_LN_HI_W,
        S_LN_LO,
        S_LN_LO_W,
        S_EV_INIT,
        S_TM_MUL,
        S_TM_W,
        S_PW_MUL,
        S_PW_W,
        S_TM_RD,
        S_ADJ,
        S_FIN,
        S_OUT
    } t_state;

    // Multiplier request and response
    typedef struct packed {
        logic start;
        logic sh46;     // 1: result scaled by 2^-46, 0: by 2^-32
    } t_mul_req;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_mul_rsp;

    // Fixed-point constants
    localparam logic signed [63:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
    localparam logic        [47:0] ONE_Q46  = 48'h4000_0000_0000;
    localparam logic signed [63:0] E_Q32    = 64'sh0000_0002_B7E1_5163;
    localparam logic signed [63:0] INV_E_Q32 = 64'sh0000_0000_5E2D_58D9;
    localparam logic signed [63:0] LN_HIGH  = 64'sh0000_0001_8000_0000;
    localparam logic signed [63:0] LN_LOW   = 64'sh0000_0000_8000_0000;
    localparam logic signed [63:0] MAX_Q64  = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam int unsigned TERM_W  = 5;
    localparam int unsigned FRAC_SH = 16;

endpackage

[hdl/tsfu_mul.sv]
// Multi-cycle signed 64x64 multiply with rounded shift and saturation.
module tsfu_mul
    import tsfu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mul_req           i_req,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output t_mul_rsp           o_rsp,
    output logic signed [63:0] o_res
);

    logic               r_busy;
    logic [2:0]         r_step;
    logic [63:0]        r_ma;
    logic [63:0]        r_mb;
    logic               r_neg;
    logic               r_sh46;
    logic [63:0]        r_prod;
    logic [127:0]       r_acc;
    logic               r_done;
    logic               r_ovf;
    logic signed [63:0] r_res;

    logic [31:0]  part_a;
    logic [31:0]  part_b;
    logic [127:0] addend;
    logic [127:0] rnd_sum;
    logic [127:0] quot;
    logic         over;
    logic [63:0]  qlo;

    // Partial product operands: ll, lh, hl, hh
    always_comb begin
        part_a = (r_step == 3'd2 || r_step == 3'd3) ? r_ma[63:32] : r_ma[31:0];
        part_b = r_step[0] ? r_mb[63:32] : r_mb[31:0];
    end

    // Alignment of the product taken one step earlier
    always_comb begin
        case (r_step)
            3'd1:    addend = {64'd0, r_prod};
            3'd2:    addend = {32'd0, r_prod, 32'd0};
            3'd3:    addend = {32'd0, r_prod, 32'd0};
            3'd4:    addend = {r_prod, 64'd0};
            default: addend = 128'd0;
        endcase
    end

    // Round half away from zero on the magnitude, then saturate
    always_comb begin
        rnd_sum = r_acc + (r_sh46 ? (128'd1 << 45) : (128'd1 << 31));
        quot    = r_sh46 ? (rnd_sum >> 46) : (rnd_sum >> 32);
        over    = |quot[127:63];
        qlo     = over ? 64'h7FFF_FFFF_FFFF_FFFF : quot[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd5) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma   <= i_a[63] ? (64'd0 - 64'(i_a)) : 64'(i_a);
            r_mb   <= i_b[63] ? (64'd0 - 64'(i_b)) : 64'(i_b);
            r_neg  <= i_a[63] ^ i_b[63];
            r_sh46 <= i_req.sh46;
            r_acc  <= 128'd0;
        end else if (r_busy) begin
            if (r_step <= 3'd3) begin
                r_prod <= part_a * part_b;
            end
            if (r_step >= 3'd1 && r_step <= 3'd4) begin
                r_acc <= r_acc + addend;
            end
            if (r_step == 3'd5) begin
                r_ovf <= over;
                r_res <= r_neg ? -$signed(qlo) : $signed(qlo);
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_res      = r_res;

endmodule

[hdl/tsfu_div.sv]
// Bit-serial divider giving the quotient rounded to nearest, ties up.
module tsfu_div #(
    parameter int DW = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [63:0]   o_quo
);

    logic          r_busy;
    logic [6:0]    r_cnt;
    logic [63:0]   r_num;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [63:0]   r_quo;
    logic          r_done;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;

    // One restoring step
    always_comb begin
        trial = {r_rem, r_num[63]};
        fits  = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num + 64'(i_den >> 1);
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[62:0], 1'b0};
            r_rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
            r_quo <= {r_quo[62:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[hdl/taylor_series_function_unit.sv]
// Top level of the Taylor-series function unit: sequencer, table and evaluation.
//
// Evaluates sin, cos, sinh, cosh, tanh, exp, arctan or ln of a signed Q16.16
// argument as a truncated power series, with one shared 64x64 multiplier
// (four 32x32 partial products) under a sequencer that starts each product
// and waits for its done strobe.
// After any register write the first item also rebuilds the Q2.46 coefficient
// table: the leading coefficient is written directly, then each further
// coefficient comes from the bit-serial divider, for tanh after a convolution
// of the earlier coefficients. Each further series term takes d power
// multiplies, d being 1 for exp and ln and 2 otherwise, and ln first runs
// its range-reduction steps.
// Only one item is in flight; the result sits in an output register, and
// o_m_axis_tuser carries domain_error in bit 0 and overflow_flag in bit 1.
module taylor_series_function_unit
    import tsfu_pkg::*;
#(
    parameter int MAX_TERMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] x_value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] result_value
    output logic [1:0]  o_m_axis_tuser,   // [0] domain_error, [1] overflow_flag
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int EW = $clog2(2 * MAX_TERMS + 1);
    localparam int DW = $clog2(4 * MAX_TERMS * MAX_TERMS);

    t_state r_state;
    t_state n_state;

    // Configuration
    t_func             r_fs;
    logic [TERM_W-1:0] r_tc;
    logic              r_tvalid;

    // Working registers
    logic signed [31:0] r_x;
    logic signed [63:0] r_xq;
    logic signed [63:0] r_p;
    logic signed [63:0] r_acc;
    logic               r_ovf;
    logic signed [7:0]  r_adj;
    logic [IW-1:0]      r_i;
    logic [IW-1:0]      r_j;
    logic               r_k;
    logic [EW-1:0]      r_e;
    logic [47:0]        r_prev;
    logic [63:0]        r_sum;
    logic [47:0]        r_opa;

    // Pending and output result
    logic [31:0] r_res;
    logic        r_dom;
    logic        r_rovf;
    logic        r_m_tvalid;
    logic [31:0] r_m_tdata;
    logic [1:0]  r_m_tuser;

    // Coefficient magnitude store
    logic [47:0]   r_mem [MAX_TERMS];
    logic [47:0]   r_rd_data;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [47:0]   mem_wdata;

    // Shared units
    t_mul_req           mul_req;
    t_mul_rsp           mul_rsp;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic signed [63:0] mul_res;
    logic               div_start;
    logic [63:0]        div_num;
    logic [DW-1:0]      div_den;
    logic               div_done;
    logic [63:0]        div_quo;

    // Derived controls
    logic [5:0]         n_wide;
    logic [IW-1:0]      last_i;
    logic               in_xfer;
    logic               out_free;
    logic               alternate;
    logic               two_steps;
    logic               odd_start;
    logic signed [63:0] coef;
    logic [DW-1:0]      ep1;
    logic [DW-1:0]      ep2;
    logic [DW-1:0]      two_i1;
    logic signed [64:0] add_a;
    logic signed [64:0] add_b;
    logic signed [64:0] add_s;
    logic signed [63:0] sat_s;
    logic               sat_o;
    logic [63:0]        acc_mag;
    logic [63:0]        acc_rnd;
    logic [47:0]        acc_m;

    tsfu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_rsp   (mul_rsp),
        .o_res   (mul_res)
    );

    tsfu_div #(
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Effective term count and function classes
    always_comb begin
        if (r_tc == '0) begin
            n_wide = 6'd1;
        end else if (6'(r_tc) > 6'(MAX_TERMS)) begin
            n_wide = 6'(MAX_TERMS);
        end else begin
            n_wide = 6'(r_tc);
        end
        last_i    = IW'(n_wide - 6'd1);
        alternate = r_fs inside {F_SIN, F_COS, F_TANH, F_ATAN, F_LN};
        two_steps = !(r_fs inside {F_EXP, F_LN});
        odd_start = !(r_fs inside {F_COS, F_COSH, F_EXP});
        in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
        out_free  = !r_m_tvalid || i_m_axis_tready;
    end

    // Signed coefficient from the stored magnitude
    always_comb begin
        coef = (alternate && r_i[0]) ? -$signed({16'd0, r_rd_data})
                                     :  $signed({16'd0, r_rd_data});
    end

    // Divisor terms
    always_comb begin
        ep1    = DW'(r_e) + DW'(1);
        ep2    = DW'(r_e) + DW'(2);
        two_i1 = (DW'(r_i) << 1) + DW'(1);
    end

    // Saturating accumulate, operand chosen by state
    always_comb begin
        add_a = 65'(r_acc);
        if (r_state == S_ADJ) begin
            add_b = 65'($signed({{24{r_adj[7]}}, r_adj, 32'd0}));
        end else begin
            add_b = 65'(mul_res);
        end
        add_s = add_a + add_b;
        sat_o = 1'b0;
        sat_s = add_s[63:0];
        if (add_s > 65'(MAX_Q64)) begin
            sat_s = MAX_Q64;
            sat_o = 1'b1;
        end else if (add_s < -65'(MAX_Q64)) begin
            sat_s = -MAX_Q64;
            sat_o = 1'b1;
        end
    end

    // Final rounding to Q16.16
    always_comb begin
        acc_mag = r_acc[63] ? (64'd0 - 64'(r_acc)) : 64'(r_acc);
        acc_rnd = acc_mag + 64'd32768;
        acc_m   = acc_rnd[63:FRAC_SH];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = r_tvalid ? S_EV_START : S_TB_START;
                end
            end
            S_TB_START: begin
                n_state = (last_i == '0) ? S_EV_START : S_TB_STEP;
            end
            S_TB_STEP: begin
                n_state = (r_fs == F_TANH) ? S_CV_RDA : S_TB_DSTART;
            end
            S_CV_RDA:    n_state = S_CV_RDB;
            S_CV_RDB:    n_state = S_CV_MUL;
            S_CV_MUL:    n_state = S_CV_WAIT;
            S_CV_WAIT: begin
                if (mul_rsp.done) begin
                    n_state = (r_j == r_i - IW'(1)) ? S_TB_DSTART : S_CV_RDA;
                end
            end
            S_TB_DSTART: n_state = S_TB_DIV;
            S_TB_DIV: begin
                if (div_done) begin
                    n_state = (r_i == last_i) ? S_EV_START : S_TB_STEP;
                end
            end
            S_EV_START: begin
                if (r_fs == F_LN && r_x <= 0) begin
                    n_state = S_OUT;
                end else if (r_fs == F_LN) begin
                    n_state = S_LN_HI;
                end else begin
                    n_state = S_EV_INIT;
                end
            end
            S_LN_HI:   n_state = (r_xq > LN_HIGH) ? S_LN_HI_W : S_LN_LO;
            S_LN_HI_W: n_state = mul_rsp.done ? S_LN_HI : S_LN_HI_W;
            S_LN_LO:   n_state = (r_xq < LN_LOW) ? S_LN_LO_W : S_EV_INIT;
            S_LN_LO_W: n_state = mul_rsp.done ? S_LN_LO : S_LN_LO_W;
            S_EV_INIT: n_state = S_TM_MUL;
            S_TM_MUL:  n_state = S_TM_W;
            S_TM_W: begin
                if (mul_rsp.done) begin
                    n_state = (r_i == last_i) ? S_ADJ : S_PW_MUL;
                end
            end
            S_PW_MUL:  n_state = S_PW_W;
            S_PW_W: begin
                if (mul_rsp.done) begin
                    n_state = (two_steps && !r_k) ? S_PW_MUL : S_TM_RD;
                end
            end
            S_TM_RD:   n_state = S_TM_MUL;
            S_ADJ:     n_state = S_FIN;
            S_FIN:     n_state = S_OUT;
            S_OUT:     n_state = out_free ? S_IDLE : S_OUT;
            default:   n_state = S_IDLE;
        endcase
    end

    // Unit controls and table access
    always_comb begin
        mul_req.start = 1'b0;
        mul_req.sh46  = 1'b0;
        mul_a         = r_xq;
        mul_b         = r_xq;
        div_start     = 1'b0;
        div_num       = 64'(r_prev);
        div_den       = two_i1;
        rd_addr       = r_i;
        mem_we        = 1'b0;
        mem_waddr     = r_i;
        mem_wdata     = div_quo[47:0];
        case (r_state)
            S_TB_START: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = ONE_Q46;
            end
            S_CV_RDA: rd_addr = r_j;
            S_CV_RDB: rd_addr = r_i - r_j - IW'(1);
            S_CV_MUL: begin
                mul_req.start = 1'b1;
                mul_req.sh46  = 1'b1;
                mul_a         = $signed({16'd0, r_opa});
                mul_b         = $signed({16'd0, r_rd_data});
            end
            S_TB_DSTART: begin
                div_start = 1'b1;
                case (r_fs)
                    F_SIN, F_COS, F_SINH, F_COSH: begin
                        div_num = 64'(r_prev);
                        div_den = DW'(ep1 * ep2);
                    end
                    F_TANH: begin
                        div_num = r_sum;
                        div_den = two_i1;
                    end
                    F_EXP: begin
                        div_num = 64'(r_prev);
                        div_den = DW'(r_i);
                    end
                    F_ATAN: begin
                        div_num = 64'(ONE_Q46);
                        div_den = two_i1;
                    end
                    default: begin
                        div_num = 64'(ONE_Q46);
                        div_den = DW'(r_i) + DW'(1);
                    end
                endcase
            end
            S_TB_DIV: mem_we = div_done;
            S_LN_HI: begin
                mul_req.start = r_xq > LN_HIGH;
                mul_b         = INV_E_Q32;
            end
            S_LN_LO: begin
                mul_req.start = r_xq < LN_LOW;
                mul_b         = E_Q32;
            end
            S_EV_INIT: rd_addr = '0;
            S_TM_MUL: begin
                mul_req.start = 1'b1;
                mul_req.sh46  = 1'b1;
                mul_a         = r_p;
                mul_b         = coef;
            end
            S_PW_MUL: begin
                mul_req.start = 1'b1;
                mul_a         = r_p;
                mul_b         = r_xq;
            end
            default: ;
        endcase
    end

    // Not ready while reset is held
    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

    // Coefficient store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fs       <= F_SIN;
            r_tc       <= TERM_W'(8);
            r_tvalid   <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_TB_START && last_i == '0) begin
                r_tvalid <= 1'b1;
            end
            if (r_state == S_TB_DIV && div_done && r_i == last_i) begin
                r_tvalid <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FUNC: begin
                        r_fs     <= t_func'(i_cfg_data[2:0]);
                        r_tvalid <= 1'b0;
                    end
                    REG_TERMS: begin
                        r_tc     <= i_cfg_data;
                        r_tvalid <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_x <= $signed(i_s_axis_tdata);
                end
            end
            S_TB_START: begin
                r_prev <= ONE_Q46;
                r_i    <= IW'(1);
                r_e    <= (r_fs == F_COS || r_fs == F_COSH) ? EW'(0) : EW'(1);
            end
            S_TB_STEP: begin
                r_j   <= '0;
                r_sum <= 64'd0;
            end
            S_CV_RDB: r_opa <= r_rd_data;
            S_CV_WAIT: begin
                if (mul_rsp.done) begin
                    r_sum <= r_sum + 64'(mul_res);
                    r_j   <= r_j + IW'(1);
                end
            end
            S_TB_DIV: begin
                if (div_done) begin
                    r_prev <= div_quo[47:0];
                    r_e    <= r_e + EW'(2);
                    r_i    <= r_i + IW'(1);
                end
            end
            S_EV_START: begin
                r_xq  <= $signed({{16{r_x[31]}}, r_x, 16'd0});
                r_acc <= 64'sd0;
                r_ovf <= 1'b0;
                r_adj <= 8'sd0;
                if (r_fs == F_LN && r_x <= 0) begin
                    r_res  <= 32'd0;
                    r_dom  <= 1'b1;
                    r_rovf <= 1'b0;
                end
            end
            S_LN_HI_W: begin
                if (mul_rsp.done) begin
                    r_xq  <= mul_res;
                    r_ovf <= r_ovf | mul_rsp.ovf;
                    r_adj <= r_adj + 8'sd1;
                end
            end
            S_LN_LO: begin
                if (!(r_xq < LN_LOW)) begin
                    r_xq <= r_xq - ONE_Q32;
                end
            end
            S_LN_LO_W: begin
                if (mul_rsp.done) begin
                    r_xq  <= mul_res;
                    r_ovf <= r_ovf | mul_rsp.ovf;
                    r_adj <= r_adj - 8'sd1;
                end
            end
            S_EV_INIT: begin
                r_p <= odd_start ? r_xq : ONE_Q32;
                r_i <= '0;
            end
            S_TM_W: begin
                if (mul_rsp.done) begin
                    r_acc <= sat_s;
                    r_ovf <= r_ovf | mul_rsp.ovf | sat_o;
                    r_k   <= 1'b0;
                    if (r_i != last_i) begin
                        r_i <= r_i + IW'(1);
                    end
                end
            end
            S_PW_W: begin
                if (mul_rsp.done) begin
                    r_p   <= mul_res;
                    r_ovf <= r_ovf | mul_rsp.ovf;
                    r_k   <= 1'b1;
                end
            end
            S_ADJ: begin
                r_acc <= sat_s;
                r_ovf <= r_ovf | sat_o;
            end
            S_FIN: begin
                r_dom <= 1'b0;
                if (r_ovf) begin
                    r_res  <= r_acc[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    r_rovf <= 1'b1;
                end else if (!r_acc[63]) begin
                    r_res  <= (acc_m > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_m[31:0];
                    r_rovf <= acc_m > 48'h7FFF_FFFF;
                end else begin
                    r_res  <= (acc_m > 48'h8000_0000) ? 32'h8000_0000
                                                       : (32'd0 - acc_m[31:0]);
                    r_rovf <= acc_m > 48'h8000_0000;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_m_tdata <= r_res;
                    r_m_tuser <= {r_rovf, r_dom};
                end
            end
            default: ;
        endcase
    end

endmodule

[bench/tb_taylor_series_function_unit.sv]
// Self-checking bench for the Taylor-series function unit: random and directed stream traffic.
module tb_taylor_series_function_unit;
    import tsfu_pkg::*;

    typedef struct {
        logic [31:0] value;
        logic        dom_err;
        logic        sat;
    } t_series_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] x_value
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;   // [31:0] result_value
    logic [1:0]  o_m_axis_tuser;   // [0] domain_error, [1] overflow_flag
    logic        i_cfg_we;
    logic [0:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;

    taylor_series_function_unit uut (.*);

    // Shadow of the block's configuration and coefficient table
    logic [2:0]         sh_func;
    logic [4:0]         sh_terms;
    logic signed [63:0] coef_tab [16];
    bit                 coef_ok;

    logic [31:0]  x_pending [$];
    t_series_out  results_due [$];
    int           fails;
    int           n_sent;
    int           n_checked;
    int           n_sat;
    int           n_dom;
    bit           no_idle;
    bit           hold_go;
    bit           send_hold;
    int           hold_left;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // Rounded, saturating fixed-point product: round(a*b / 2^sh), ties away from zero
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
            input logic signed [63:0] b, input int sh, inout bit ov);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] pr;
        logic [63:0]  q;
        ma = a[63] ? 64'd0 - a : a;
        mb = b[63] ? 64'd0 - b : b;
        pr = {64'd0, ma} * {64'd0, mb};
        pr = (pr + (128'd1 << (sh - 1))) >> sh;
        if (pr > 128'h7FFF_FFFF_FFFF_FFFF) begin
            ov = 1'b1;
            q = MAX_Q64;
        end else begin
            q = pr[63:0];
        end
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
            input logic signed [63:0] b, inout bit ov);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(MAX_Q64)) begin
            ov = 1'b1;
            return MAX_Q64;
        end
        if (s < -65'(MAX_Q64)) begin
            ov = 1'b1;
            return -MAX_Q64;
        end
        return s[63:0];
    endfunction

    function automatic int terms_in_use();
        if (sh_terms == 0) return 1;
        if (sh_terms > 16) return 16;
        return sh_terms;
    endfunction

    function automatic logic [63:0] udiv_rnd(input logic [63:0] m, input logic [63:0] d);
        return (m + d / 2) / d;
    endfunction

    // Rebuild the Q2.46 coefficients for the current function and term count
    function automatic void rebuild_coefs();
        logic [63:0]        mag [16];
        logic [63:0]        e;
        logic signed [63:0] acc;
        bit                 dummy;
        bit                 alt;
        int                 n;
        t_func              f;
        n = terms_in_use();
        f = t_func'(sh_func);
        alt = (f == F_SIN || f == F_COS || f == F_TANH || f == F_ATAN || f == F_LN);
        e = (f == F_COS || f == F_COSH) ? 0 : 1;
        mag[0] = 64'(ONE_Q46);
        for (int i = 1; i < n; i++) begin
            case (f)
                F_SIN, F_COS, F_SINH, F_COSH: begin
                    mag[i] = udiv_rnd(mag[i-1], (e + 1) * (e + 2));
                    e += 2;
                end
                F_TANH: begin
                    acc = 0;
                    for (int j = 0; j < i; j++)
                        acc += fx_mul(mag[j], mag[i-1-j], 46, dummy);
                    mag[i] = udiv_rnd(acc, 2 * i + 1);
                end
                F_EXP:  mag[i] = udiv_rnd(mag[i-1], i);
                F_ATAN: mag[i] = udiv_rnd(64'(ONE_Q46), 2 * i + 1);
                default: mag[i] = udiv_rnd(64'(ONE_Q46), i + 1);
            endcase
        end
        for (int i = 0; i < n; i++)
            coef_tab[i] = (alt && i[0]) ? -$signed(mag[i]) : $signed(mag[i]);
        coef_ok = 1'b1;
    endfunction

    // Series value of one argument under the shadow configuration
    function automatic t_series_out series_eval(input logic [31:0] x);
        t_series_out        r;
        logic signed [63:0] xq;
        logic signed [63:0] p;
        logic signed [63:0] acc;
        logic [63:0]        m;
        bit                 ov;
        int                 adj;
        int                 n;
        int                 d;
        t_func              f;
        if (!coef_ok) rebuild_coefs();
        n = terms_in_use();
        f = t_func'(sh_func);
        ov = 1'b0;
        adj = 0;
        acc = 0;
        if (f == F_LN && $signed(x) <= 0) begin
            r.value = '0;
            r.dom_err = 1'b1;
            r.sat = 1'b0;
            return r;
        end
        xq = 64'($signed(x)) <<< 16;
        if (f == F_LN) begin
            while (xq > LN_HIGH) begin
                xq = fx_mul(xq, INV_E_Q32, 32, ov);
                adj++;
            end
            while (xq < LN_LOW) begin
                xq = fx_mul(xq, E_Q32, 32, ov);
                adj--;
            end
            xq -= ONE_Q32;
        end
        d = (f == F_EXP || f == F_LN) ? 1 : 2;
        p = (f == F_COS || f == F_COSH || f == F_EXP) ? ONE_Q32 : xq;
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                for (int k = 0; k < d; k++) p = fx_mul(p, xq, 32, ov);
            acc = fx_add(acc, fx_mul(p, coef_tab[i], 46, ov), ov);
        end
        acc = fx_add(acc, 64'(adj) * ONE_Q32, ov);
        if (ov) begin
            r.value = acc[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            m = ((acc[63] ? 64'd0 - acc : acc) + 64'd32768) >> 16;
            if (!acc[63]) begin
                if (m > 64'h7FFF_FFFF) begin
                    m = 64'h7FFF_FFFF;
                    ov = 1'b1;
                end
                r.value = m[31:0];
            end else begin
                if (m > 64'h8000_0000) begin
                    m = 64'h8000_0000;
                    ov = 1'b1;
                end
                r.value = 32'd0 - m[31:0];
            end
        end
        r.dom_err = 1'b0;
        r.sat = ov;
        return r;
    endfunction

    // Driver: offer pending arguments, predict each one on its transfer
    always @(posedge i_clk) begin
        bit take;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                results_due.push_back(series_eval(i_s_axis_tdata));
                n_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                take = !send_hold && x_pending.size() > 0 &&
                       (no_idle || $urandom_range(99) >= 16);
                if (take) i_s_axis_tdata <= x_pending.pop_front();
                i_s_axis_tvalid <= take;
            end
        end
    end

    // Monitor: check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_series_out want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (results_due.size() == 0) begin
                    $error("result transfer with nothing expected: %h", o_m_axis_tdata);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    n_checked++;
                    n_sat += want.sat;
                    n_dom += want.dom_err;
                    if (o_m_axis_tdata !== want.value) begin
                        $error("result_value: expected %h, got %h", want.value,
                               o_m_axis_tdata);
                        fails++;
                    end
                    if (o_m_axis_tuser[0] !== want.dom_err) begin
                        $error("domain_error: expected %b, got %b", want.dom_err,
                               o_m_axis_tuser[0]);
                        fails++;
                    end
                    if (o_m_axis_tuser[1] !== want.sat) begin
                        $error("overflow_flag: expected %b, got %b", want.sat,
                               o_m_axis_tuser[1]);
                        fails++;
                    end
                end
            end
            if (hold_go) hold_left <= 400;
            else if (hold_left > 0) hold_left <= hold_left - 1;
            i_m_axis_tready <= !hold_go && hold_left == 0 &&
                               (no_idle || $urandom_range(99) >= 16);
        end
    end

    task automatic cfg_write(input logic [0:0] idx, input logic [4:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_FUNC) sh_func = val[2:0];
        else sh_terms = val;
        coef_ok = 1'b0;
    endtask

    task automatic setup(input logic [4:0] func_val, input logic [4:0] terms_val);
        if ($urandom_range(1)) begin
            cfg_write(REG_FUNC, func_val);
            cfg_write(REG_TERMS, terms_val);
        end else begin
            cfg_write(REG_TERMS, terms_val);
            cfg_write(REG_FUNC, func_val);
        end
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic drain();
        while (x_pending.size() > 0 || i_s_axis_tvalid || results_due.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_x(input t_func f);
        int sel;
        sel = $urandom_range(9);
        if (sel < 3) return $urandom();
        if (f == F_LN && sel < 8) return $urandom_range(32'h7FFF_FFFF, 1) >> $urandom_range(30);
        if (sel < 6) return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        return 32'($signed($urandom_range(64 << 16)) - (32 << 16));
    endfunction

    initial begin
        logic [31:0] edge_x [3];
        t_func       f;
        logic [4:0]  tc;
        int          cnt;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        sh_func = F_SIN;
        sh_terms = 5'd8;
        coef_ok = 1'b0;
        fails = 0;
        n_sent = 0;
        n_checked = 0;
        n_sat = 0;
        n_dom = 0;
        no_idle = 1'b0;
        hold_go = 1'b0;
        send_hold = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration first: sin with eight terms
        x_pending.push_back(32'h0001_0000);
        drain();

        // Directed: every function, extreme arguments, term count zero and above the limit
        for (int fi = 0; fi < 8; fi++) begin
            f = t_func'(fi);
            tc = (fi == 0) ? 5'd0 : (fi == 1) ? 5'd31 : (fi == 7) ? 5'd16 : 5'(1 + fi);
            setup({2'b11, f}, tc);
            if (f == F_LN) begin
                edge_x = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001};
                x_pending.push_back(32'h7FFF_FFFF);
                x_pending.push_back(32'hFFFF_FFFF);
            end else begin
                edge_x = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000};
            end
            foreach (edge_x[k]) x_pending.push_back(edge_x[k]);
            drain();
        end

        // Random phases, each with a fresh configuration
        cnt = 0;
        for (int ph = 0; cnt < 1550; ph++) begin
            f = t_func'($urandom_range(7));
            tc = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(6, 1));
            setup({2'($urandom_range(3)), f}, tc);
            @(posedge i_clk);
            no_idle <= (ph == 3);
            for (int k = $urandom_range(60, 30); k > 0; k--) begin
                x_pending.push_back(rand_x(f));
                cnt++;
            end
            // Long receiver hold-off while the sender keeps offering
            if (ph == 5 || ph == 17) begin
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            // Sender pauses mid-phase until every result is back
            if (ph == 9) begin
                while (x_pending.size() > 20) @(posedge i_clk);
                send_hold <= 1'b1;
                @(posedge i_clk);
                while (i_s_axis_tvalid || results_due.size() > 0) @(posedge i_clk);
                send_hold <= 1'b0;
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            fails++;
        end
        $display("Covered %0d arguments over all eight functions and term counts 0..31;",
                 n_sent);
        $display("%0d results checked, %0d saturated, %0d domain errors.",
                 n_checked, n_sat, n_dom);
        if (fails == 0) begin
            $display("** taylor_series_function_unit: PASSED **");
        end else begin
            $display("** taylor_series_function_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400_000_000;
        $display("** taylor_series_function_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hdl/tsfu_pkg.sv
hdl/tsfu_mul.sv
hdl/tsfu_div.sv
hdl/taylor_series_function_unit.sv
bench/tb_taylor_series_function_unit.sv
